### hw/rtl/oli_pkg.sv
// Shared types and constants for the ordered list insert/remove block.
`timescale 1ns / 1ps

package oli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int LEN_W = 5;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_POP_FRONT  = 3'd1,
    MODE_REMOVE_END = 3'd2,
    MODE_REMOVE_AT  = 3'd3,
    MODE_REMOVE_VAL = 3'd4,
    MODE_INSERT_AT  = 3'd5,
    MODE_READ_AT    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [VAL_W-1:0]  item_value;
    logic        [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  affected_value;
    logic        [LEN_W-1:0]  list_length;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
  } ctrl_cmd_t;

endpackage

### hw/rtl/oli_ctrl.sv
// Sequencing state machine for the ordered list block.
`timescale 1ns / 1ps

module oli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output oli_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load  = (state_r == S_IDLE) && in_valid;
    cmd.eval  = (state_r == S_EVAL);
    cmd.apply = (state_r == S_APPLY) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/oli_datapath.sv
// List storage, search, shift network and result register for the ordered list block.
`timescale 1ns / 1ps

module oli_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  oli_pkg::ctrl_cmd_t cmd,
  input  oli_pkg::in_item_t  in_data,
  output oli_pkg::out_item_t out_data
);

  localparam int CMP_W = (oli_pkg::CNT_W > oli_pkg::POS_W) ? oli_pkg::CNT_W : oli_pkg::POS_W;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_REMOVE,
    ACT_INSERT,
    ACT_READ
  } act_t;

  logic signed [oli_pkg::VAL_W-1:0] entries_r [oli_pkg::CAPACITY];
  logic signed [oli_pkg::VAL_W-1:0] entries_nxt [oli_pkg::CAPACITY];
  logic [oli_pkg::CNT_W-1:0]        count_r;
  logic [oli_pkg::CNT_W-1:0]        count_nxt;
  oli_pkg::in_item_t                item_r;
  oli_pkg::status_t                 status_r;
  oli_pkg::status_t                 status_nxt;
  act_t                             act_r;
  act_t                             act_nxt;
  logic [oli_pkg::IDX_W-1:0]        idx_r;
  logic [oli_pkg::IDX_W-1:0]        idx_nxt;
  oli_pkg::out_item_t               out_r;

  logic [oli_pkg::CAPACITY-1:0]     hit;
  logic [oli_pkg::IDX_W-1:0]        hit_idx;
  logic                             any_hit;
  logic                             full;
  logic                             empty;
  logic [CMP_W-1:0]                 pos_c;
  logic [CMP_W-1:0]                 cnt_c;
  logic signed [oli_pkg::VAL_W-1:0] affected;

  always_comb begin
    for (int i = 0; i < oli_pkg::CAPACITY; i++) begin
      hit[i] = (oli_pkg::CNT_W'(i) < count_r) && (entries_r[i] == item_r.item_value);
    end
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = oli_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = oli_pkg::IDX_W'(i);
      end
    end
  end

  assign full  = (count_r >= oli_pkg::CNT_W'(oli_pkg::CAPACITY));
  assign empty = (count_r == '0);
  assign pos_c = CMP_W'(item_r.position);
  assign cnt_c = CMP_W'(count_r);

  always_comb begin
    status_nxt = oli_pkg::ST_DONE;
    act_nxt    = ACT_NONE;
    idx_nxt    = oli_pkg::IDX_W'(item_r.position);
    unique case (item_r.mode)
      oli_pkg::MODE_PUSH_FRONT: begin
        idx_nxt = '0;
        if (full) status_nxt = oli_pkg::ST_FULL;
        else act_nxt = ACT_INSERT;
      end
      oli_pkg::MODE_POP_FRONT: begin
        idx_nxt = '0;
        if (empty) status_nxt = oli_pkg::ST_EMPTY;
        else act_nxt = ACT_REMOVE;
      end
      oli_pkg::MODE_REMOVE_END: begin
        idx_nxt = oli_pkg::IDX_W'(count_r - oli_pkg::CNT_W'(1));
        if (empty) status_nxt = oli_pkg::ST_EMPTY;
        else act_nxt = ACT_REMOVE;
      end
      oli_pkg::MODE_REMOVE_AT: begin
        if (empty) status_nxt = oli_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) status_nxt = oli_pkg::ST_RANGE;
        else act_nxt = ACT_REMOVE;
      end
      oli_pkg::MODE_REMOVE_VAL: begin
        idx_nxt = hit_idx;
        if (empty) status_nxt = oli_pkg::ST_EMPTY;
        else if (!any_hit) status_nxt = oli_pkg::ST_NOTFOUND;
        else act_nxt = ACT_REMOVE;
      end
      oli_pkg::MODE_INSERT_AT: begin
        if (full) status_nxt = oli_pkg::ST_FULL;
        else if (pos_c > cnt_c) status_nxt = oli_pkg::ST_RANGE;
        else act_nxt = ACT_INSERT;
      end
      oli_pkg::MODE_READ_AT: begin
        if (empty) status_nxt = oli_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) status_nxt = oli_pkg::ST_RANGE;
        else act_nxt = ACT_READ;
      end
      default: begin
        act_nxt = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    affected    = '0;
    if (act_r == ACT_REMOVE || act_r == ACT_READ) begin
      affected = entries_r[idx_r];
    end
    if (act_r == ACT_REMOVE) begin
      for (int i = 0; i < oli_pkg::CAPACITY - 1; i++) begin
        if (i >= int'(idx_r)) entries_nxt[i] = entries_r[i+1];
      end
      count_nxt = count_r - oli_pkg::CNT_W'(1);
    end else if (act_r == ACT_INSERT) begin
      for (int i = 1; i < oli_pkg::CAPACITY; i++) begin
        if (i > int'(idx_r)) entries_nxt[i] = entries_r[i-1];
      end
      entries_nxt[idx_r] = item_r.item_value;
      count_nxt = count_r + oli_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.eval) begin
      status_r <= status_nxt;
      act_r    <= act_nxt;
      idx_r    <= idx_nxt;
    end
    if (cmd.apply) begin
      entries_r <= entries_nxt;
      out_r     <= '{status: status_r, affected_value: affected,
                     list_length: oli_pkg::LEN_W'(count_nxt)};
    end
  end

  assign out_data = out_r;

endmodule

### hw/rtl/ordered_list_insert_remove.sv
// Top level of the bounded ordered list: push, pop, remove, insert and read by position.
// A result beat is offered once its input beat has passed the load, search and shift steps.
// An input beat is taken only while the sequencer is idle, once the last item's shift is done.
// A waiting result beat does not block the next input beat; only the shift step waits for it.
// Reset (rst_n low, synchronous) empties the list and drops any pending result beat.
// List storage is not cleared by reset; entries at or beyond the length are never read.
`timescale 1ns / 1ps

module ordered_list_insert_remove (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output oli_pkg::out_item_t out_data
);

  oli_pkg::ctrl_cmd_t cmd;

  oli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  oli_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again directly after a beat");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.list_length <= oli_pkg::LEN_W'(oli_pkg::CAPACITY)))
    else $error("list length above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == oli_pkg::ST_FULL)
      |-> (out_data.list_length == oli_pkg::LEN_W'(oli_pkg::CAPACITY)))
    else $error("full status on a list that is not full");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == oli_pkg::ST_EMPTY) |-> (out_data.list_length == '0))
    else $error("empty status on a list that is not empty");
`endif

endmodule
